/* design/ppr_pkg.sv */
// ----------------------------------------------------------------------------
// ppr_pkg: shared constants for the point/plane reflection block
// Field widths, register indexes and the quotient range of the divider lanes.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int CRD_W    = 32;            // coordinate and normal component width
  localparam int OFS_W    = 48;            // plane constant width
  localparam int DEN_W    = 64;            // width of a^2+b^2+c^2
  localparam int QUO_BITS = 35;            // quotient bits kept by a divider lane
  localparam int DIV_LAT  = QUO_BITS + 2;  // divider lane latency in cycles
  localparam int RES_W    = QUO_BITS + 2;  // unsaturated result width

  // largest reflection offset ever applied (2^34)
  localparam logic [QUO_BITS:0] QUO_CAP = {2'b01, {(QUO_BITS - 1){1'b0}}};

  typedef enum logic [1:0] {
    REG_A      = 2'd0,
    REG_B      = 2'd1,
    REG_C      = 2'd2,
    REG_OFFSET = 2'd3
  } cfg_reg_t;

endpackage

/* design/ppr_div.sv */
// ----------------------------------------------------------------------------
// ppr_div: pipelined rounding divider lane
// Unsigned num/den, one quotient bit per stage, rounded to nearest with ties
// up, capped at QUO_CAP. Quotients at or above 2^QUO_BITS go straight to cap.
// ----------------------------------------------------------------------------
module ppr_div #(
  parameter int NUM_W = 129
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [NUM_W-1:0]                   num_i,
  input  logic [ppr_pkg::DEN_W-1:0]          den_i,
  output logic [ppr_pkg::QUO_BITS-1:0]       quo_o
);

  localparam int QB = ppr_pkg::QUO_BITS;
  localparam int DW = ppr_pkg::DEN_W;
  localparam int HW = NUM_W - QB;

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] low_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic          ovf_r [QB+1];
  logic [QB-1:0] quo_out_r;

  logic [HW-1:0] hi;
  assign hi = num_i[NUM_W-1:QB];

  // split off the high part; a high part at or above den means a huge quotient
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= (hi >= HW'(den_i));
      rem_r[0] <= hi[DW-1:0];
      low_r[0] <= num_i[QB-1:0];
      quo_r[0] <= '0;
    end
  end

  // one restoring step per stage
  for (genvar g = 0; g < QB; g++) begin : g_step
    logic [DW:0] trial;
    logic        take;
    assign trial = {rem_r[g], low_r[g][QB-1]};
    assign take  = (trial >= {1'b0, den_i});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1] <= take ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
        low_r[g+1] <= {low_r[g][QB-2:0], 1'b0};
        quo_r[g+1] <= {quo_r[g][QB-2:0], take};
        ovf_r[g+1] <= ovf_r[g];
      end
    end
  end

  // round on the remainder, then cap
  logic              round_up;
  logic [QB:0]       quo_rnd;
  assign round_up = ({rem_r[QB], 1'b0} >= {1'b0, den_i});
  assign quo_rnd  = {1'b0, quo_r[QB]} + (QB+1)'(round_up);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_r[QB] || (quo_rnd > ppr_pkg::QUO_CAP)) begin
        quo_out_r <= ppr_pkg::QUO_CAP[QB-1:0];
      end else begin
        quo_out_r <= quo_rnd[QB-1:0];
      end
    end
  end

  assign quo_o = quo_out_r;

endmodule

/* design/point_plane_reflection.sv */
// ----------------------------------------------------------------------------
// point_plane_reflection: mirror 3-D points across a configured plane
// Reflects each Q16.16 point across a*x+b*y+c*z+d=0 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Write plane_a/b/c (index 0..2, Q16.16) and plane_offset (index 3, Q32.16)
//   on the cfg port while no point is in flight. Points enter on the in_
//   stream, one word per point; each yields exactly one word on out_.
//   From acceptance to out_tvalid a point passes five stages of products,
//   sums and partial products, then three divider lanes that produce one
//   quotient bit per stage, then the saturating output register. Throughput
//   is one point per cycle unless out_ stalls; 35 divider stages set the depth.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and in_tready falls; nothing is lost or repeated.
//   out_tuser[0] flags an all-zero normal (point passed through unchanged),
//   out_tuser[1] flags a saturated coordinate.
//   Reset empties the pipeline and loads the plane z = 0 (c = 1.0).
// ----------------------------------------------------------------------------
module point_plane_reflection #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // point_x, point_y, point_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // mirror_x, mirror_y, mirror_z
  output logic [1:0]  out_tuser   // plane_invalid, clipped
);

  localparam int CW   = ppr_pkg::CRD_W;
  localparam int DL   = ppr_pkg::DIV_LAT;
  localparam int DSW  = ppr_pkg::OFS_W + FRAC_BITS;
  localparam int SW   = ((DSW > 64) ? DSW : 64) + 2;
  localparam int NC   = (SW + 31) / 32;
  localparam int SUMW = NC * 32 + 32;
  localparam int NUMW = SUMW + 1;
  localparam int NSTG = 5 + DL + 1;
  localparam int RW   = ppr_pkg::RES_W;

  // configuration registers
  logic signed [CW-1:0]            k_r [3];
  logic signed [ppr_pkg::OFS_W-1:0] d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r[0] <= '0;
      k_r[1] <= '0;
      k_r[2] <= CW'(1) << FRAC_BITS;
      d_r    <= '0;
    end else if (cfg_we) begin
      case (ppr_pkg::cfg_reg_t'(cfg_index))
        ppr_pkg::REG_A:      k_r[0] <= cfg_wdata[CW-1:0];
        ppr_pkg::REG_B:      k_r[1] <= cfg_wdata[CW-1:0];
        ppr_pkg::REG_C:      k_r[2] <= cfg_wdata[CW-1:0];
        ppr_pkg::REG_OFFSET: d_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // derived plane terms: |k| and k*k registered from k_r, then their sum n_r
  logic [CW-1:0]             kmag_r [3];
  logic [63:0]               sq_r   [3];
  logic [ppr_pkg::DEN_W-1:0] n_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      kmag_r[i] <= k_r[i][CW-1] ? CW'(-k_r[i]) : CW'(k_r[i]);
      sq_r[i]   <= 64'(k_r[i] * k_r[i]);
    end
    n_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  // pipeline control
  logic [NSTG-1:0] v_r;
  logic            adv;

  assign adv       = !v_r[NSTG-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], in_tvalid};
    end
  end

  logic signed [CW-1:0] pin [3];
  assign pin[0] = in_tdata[31:0];
  assign pin[1] = in_tdata[63:32];
  assign pin[2] = in_tdata[95:64];

  // stage 1: k*p products
  logic signed [63:0]   kp1_r [3];
  logic signed [CW-1:0] p1_r [3], p2_r [3], p3_r [3], p4_r [3], p5_r [3];
  logic                 inv1_r, inv2_r, inv3_r, inv4_r, inv5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        kp1_r[i] <= k_r[i] * pin[i];
        p1_r[i]  <= pin[i];
      end
      inv1_r <= (k_r[0] == '0) && (k_r[1] == '0) && (k_r[2] == '0);
    end
  end

  // stage 2: plane distance numerator s = d<<F + sum(k*p)
  logic signed [DSW-1:0] dsh;
  logic signed [SW-1:0]  s2_r;
  assign dsh = {d_r, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r   <= SW'(dsh) + SW'(kp1_r[0]) + SW'(kp1_r[1]) + SW'(kp1_r[2]);
      p2_r   <= p1_r;
      inv2_r <= inv1_r;
    end
  end

  // stage 3: sign and magnitude of s
  logic [SW-1:0] mag3_r;
  logic          sneg3_r, sneg4_r, sneg5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sneg3_r <= s2_r[SW-1];
      mag3_r  <= s2_r[SW-1] ? SW'(-s2_r) : SW'(s2_r);
      p3_r    <= p2_r;
      inv3_r  <= inv2_r;
    end
  end

  // stage 4: 32x32 partial products |s| * |k|
  logic [NC*32-1:0] magx;
  logic [63:0]      pp4_r [3][NC];
  assign magx = (NC*32)'(mag3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < NC; j++) begin
          pp4_r[i][j] <= magx[32*j +: 32] * kmag_r[i];
        end
      end
      p4_r    <= p3_r;
      sneg4_r <= sneg3_r;
      inv4_r  <= inv3_r;
    end
  end

  // stage 5: assemble 2*|k|*|s|
  logic [SUMW-1:0] acc [3];
  logic [NUMW-1:0] num5_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = '0;
      for (int j = 0; j < NC; j++) begin
        acc[i] = acc[i] + (SUMW'(pp4_r[i][j]) << (32 * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num5_r[i] <= {acc[i], 1'b0};
      end
      p5_r    <= p4_r;
      sneg5_r <= sneg4_r;
      inv5_r  <= inv4_r;
    end
  end

  // divider lanes and matching sideband delay
  logic [ppr_pkg::QUO_BITS-1:0] quo [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    ppr_div #(
      .NUM_W (NUMW)
    ) u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (num5_r[g]),
      .den_i (n_r),
      .quo_o (quo[g])
    );
  end

  logic signed [CW-1:0] sbp_r [DL][3];
  logic                 sbs_r [DL];
  logic                 sbi_r [DL];

  always_ff @(posedge clk) begin
    if (adv) begin
      sbp_r[0] <= p5_r;
      sbs_r[0] <= sneg5_r;
      sbi_r[0] <= inv5_r;
      for (int j = 1; j < DL; j++) begin
        sbp_r[j] <= sbp_r[j-1];
        sbs_r[j] <= sbs_r[j-1];
        sbi_r[j] <= sbi_r[j-1];
      end
    end
  end

  // output stage: apply offset, saturate
  logic signed [RW-1:0] res [3];
  logic [CW-1:0]        sat [3];
  logic [2:0]           clip;
  logic [95:0]          odata_nxt;
  logic [95:0]          odata_r;
  logic [1:0]           ouser_nxt;
  logic [1:0]           ouser_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (k_r[i][CW-1] == sbs_r[DL-1]) begin
        res[i] = RW'(sbp_r[DL-1][i]) - $signed({2'b00, quo[i]});
      end else begin
        res[i] = RW'(sbp_r[DL-1][i]) + $signed({2'b00, quo[i]});
      end
      clip[i] = !((&res[i][RW-1:CW-1]) || !(|res[i][RW-1:CW-1]));
      if (clip[i]) begin
        sat[i] = res[i][RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        sat[i] = res[i][CW-1:0];
      end
    end
    if (sbi_r[DL-1]) begin
      odata_nxt = {sbp_r[DL-1][2], sbp_r[DL-1][1], sbp_r[DL-1][0]};
      ouser_nxt = 2'b01;
    end else begin
      odata_nxt = {sat[2], sat[1], sat[0]};
      ouser_nxt = {|clip, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      odata_r <= odata_nxt;
      ouser_r <= ouser_nxt;
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  // a pass-through word never reports saturation
  a_inv_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("plane_invalid and clipped both set");

  // an empty output register never holds back the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // divider lanes never exceed the offset cap
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4+DL] |-> ({1'b0, quo[0]} <= ppr_pkg::QUO_CAP)
                  && ({1'b0, quo[1]} <= ppr_pkg::QUO_CAP)
                  && ({1'b0, quo[2]} <= ppr_pkg::QUO_CAP))
    else $error("quotient above cap");

  // a stalled output word stays in place for the next cycle
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled output word dropped");

endmodule
